// ----- src/cdt_pkg.sv -----
// ----------------------------------------------------------------------------
// Countdown timer controller package
// Mode, display and button codes and the limits shared by the timer logic.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int TimeW   = 13;
    localparam int TotalW  = 20;
    localparam int StepW   = 10;
    localparam int LimitW  = 7;
    localparam int TickW   = 2;
    localparam int ActW    = 3;
    localparam int CfgIdxW = 2;

    localparam logic [TimeW-1:0]  TimeMax    = TimeW'(5999);
    localparam logic [TimeW-1:0]  ElapsedMax = TimeW'(8191);
    localparam logic [TotalW-1:0] TotalMax   = TotalW'(1048575);
    localparam logic [TimeW-1:0]  StartMin   = TimeW'(60);
    localparam logic [LimitW-1:0] CountMax   = LimitW'(127);

    localparam logic [StepW-1:0]  StepReset  = StepW'(60);
    localparam logic [LimitW-1:0] LimitReset = LimitW'(60);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SET   = 3'd1,
        MODE_RUN   = 3'd2,
        MODE_PAUSE = 3'd3,
        MODE_STAT  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        DISP_NONE   = 3'd0,
        DISP_BLANK  = 3'd1,
        DISP_PROMPT = 3'd2,
        DISP_TIME   = 3'd3,
        DISP_HOLD   = 3'd4,
        DISP_TOTAL  = 3'd5
    } t_disp;

    typedef enum logic [ActW-1:0] {
        ACT_NONE  = 3'd0,
        ACT_INC   = 3'd1,
        ACT_DEC   = 3'd2,
        ACT_ABORT = 3'd3,
        ACT_START = 3'd4
    } t_action;

    typedef enum logic [TickW-1:0] {
        TICK_NONE = 2'd0,
        TICK_SEC  = 2'd1,
        TICK_BUZZ = 2'd2,
        TICK_BOTH = 2'd3
    } t_tick;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_STEP  = 2'd0,
        CFG_LIMIT = 2'd1
    } t_cfg_idx;

endpackage

// ----- src/countdown_timer_controller.sv -----
// ----------------------------------------------------------------------------
// Countdown timer controller
// Five-mode countdown timer driven by one tick/button event per transfer.
// ----------------------------------------------------------------------------
// One event is accepted per clock cycle unless the input register is held, and
// each event yields exactly one result. An event passes through an input
// register and is resolved against the timer state combinationally into the
// result register; a new event may enter as the held one fires. A stall on the
// result side holds the result register and then the input register.
// Configuration writes are always ready and take effect for the next event.
module countdown_timer_controller
    import cdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CfgIdxW-1:0]   i_cfg_index,
    input  logic [StepW-1:0]     i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [TickW-1:0]     i_tick,
    input  logic [ActW-1:0]      i_action,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_mode,
    output logic [TimeW-1:0]     o_time_left,
    output logic [TotalW-1:0]    o_productive_total,
    output logic [2:0]           o_display_cmd,
    output logic                 o_beep,
    output logic                 o_reminder
);

    // configuration
    logic [StepW-1:0]  r_step;
    logic [LimitW-1:0] r_limit;

    // input register
    logic              r_in_valid;
    logic [TickW-1:0]  r_tick;
    logic [ActW-1:0]   r_action;

    // timer state
    t_mode             r_mode_reg, n_mode_reg;
    logic [TimeW-1:0]  r_remaining, n_remaining;
    logic [TimeW-1:0]  r_elapsed, n_elapsed;
    logic [TotalW-1:0] r_total, n_total;
    logic [LimitW-1:0] r_buzz_cnt, n_buzz_cnt;
    logic              r_total_shown, n_total_shown;

    // result register
    logic              r_out_valid;
    t_mode             r_out_mode;
    logic [TimeW-1:0]  r_out_time;
    logic [TotalW-1:0] r_out_total;
    t_disp             r_out_disp, n_disp;
    logic              r_out_beep, n_beep;
    logic              r_out_rem, n_rem;

    logic              fire;
    logic              in_take;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= StepReset;
            r_limit <= LimitReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEP:  r_step  <= i_cfg_data;
                CFG_LIMIT: r_limit <= i_cfg_data[LimitW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_tick   <= i_tick;
            r_action <= i_action;
        end
    end

    // event resolution
    always_comb begin
        logic              pressed;
        logic              sec;
        logic              done;
        logic [TimeW:0]    add_sum;
        logic [TimeW-1:0]  added;
        logic [TimeW-1:0]  step_ext;
        logic              sub_ok;
        logic [TimeW-1:0]  subbed;
        logic [TimeW-1:0]  dec_rem;
        logic [TimeW-1:0]  inc_el;
        logic [TotalW:0]   tot_sum;
        logic [TotalW-1:0] tot_sat;

        pressed  = (r_action == ACT_INC) || (r_action == ACT_DEC) ||
                   (r_action == ACT_ABORT) || (r_action == ACT_START);
        sec      = (r_tick == TICK_SEC) || (r_tick == TICK_BOTH);
        step_ext = TimeW'(r_step);
        add_sum  = {1'b0, r_remaining} + {1'b0, step_ext};
        added    = (add_sum > {1'b0, TimeMax}) ? TimeMax : add_sum[TimeW-1:0];
        sub_ok   = (r_remaining >= step_ext);
        subbed   = sub_ok ? (r_remaining - step_ext) : '0;
        dec_rem  = (r_remaining != '0) ? (r_remaining - 1'b1) : r_remaining;
        inc_el   = (r_remaining != '0 && r_elapsed < ElapsedMax) ?
                   (r_elapsed + 1'b1) : r_elapsed;
        tot_sum  = {1'b0, r_total} + (TotalW + 1)'(inc_el);
        tot_sat  = (tot_sum > {1'b0, TotalMax}) ? TotalMax : tot_sum[TotalW-1:0];
        done     = 1'b0;

        n_mode_reg    = r_mode_reg;
        n_remaining   = r_remaining;
        n_elapsed     = r_elapsed;
        n_total       = r_total;
        n_buzz_cnt    = r_buzz_cnt;
        n_total_shown = r_total_shown;
        n_disp        = DISP_NONE;
        n_beep        = 1'b0;
        n_rem         = 1'b0;

        unique case (r_mode_reg)
            MODE_IDLE: begin
                if (r_tick == TICK_BOTH) begin
                    n_beep = 1'b1;
                    if (r_buzz_cnt > r_limit || r_buzz_cnt == CountMax) begin
                        n_rem      = 1'b1;
                        n_buzz_cnt = '0;
                    end else begin
                        n_buzz_cnt = r_buzz_cnt + 1'b1;
                    end
                end
                if (pressed) begin
                    if (r_action == ACT_INC) begin
                        n_remaining = added;
                        n_mode_reg  = MODE_SET;
                    end else if (r_action == ACT_START) begin
                        n_mode_reg  = MODE_STAT;
                    end
                    n_disp = DISP_BLANK;
                end else begin
                    n_remaining = '0;
                    n_elapsed   = '0;
                    n_disp      = DISP_PROMPT;
                end
            end
            MODE_SET: begin
                if (!pressed) begin
                    n_disp = DISP_TIME;
                end else if (r_action == ACT_INC) begin
                    n_remaining = added;
                    n_disp      = DISP_TIME;
                end else if (r_action == ACT_DEC) begin
                    n_remaining = subbed;
                    n_disp      = DISP_TIME;
                end else if (r_action == ACT_ABORT) begin
                    n_mode_reg = MODE_IDLE;
                    n_disp     = DISP_BLANK;
                end else if (r_remaining >= StartMin) begin
                    n_mode_reg = MODE_RUN;
                    n_disp     = DISP_BLANK;
                end
            end
            MODE_RUN: begin
                if (sec) begin
                    n_remaining = dec_rem;
                    n_elapsed   = inc_el;
                    if (r_remaining != '0) begin
                        n_disp = DISP_TIME;
                    end
                    // run completes when the remaining time lands on zero
                    if (dec_rem == '0) begin
                        n_total    = tot_sat;
                        n_elapsed  = '0;
                        n_mode_reg = MODE_IDLE;
                        n_disp     = DISP_BLANK;
                        done       = 1'b1;
                    end
                end
                if (!done && pressed) begin
                    if (r_action == ACT_ABORT) begin
                        n_mode_reg = MODE_IDLE;
                        n_disp     = DISP_BLANK;
                    end else if (r_action == ACT_START) begin
                        n_mode_reg = MODE_PAUSE;
                        n_disp     = DISP_BLANK;
                    end
                end
            end
            MODE_PAUSE: begin
                if (!pressed) begin
                    n_disp = DISP_HOLD;
                end else if (r_action == ACT_INC) begin
                    n_remaining = added;
                    n_mode_reg  = MODE_SET;
                    n_disp      = DISP_BLANK;
                end else if (r_action == ACT_DEC) begin
                    n_remaining = subbed;
                    if (!sub_ok) begin
                        n_beep     = 1'b1;
                        n_mode_reg = MODE_SET;
                        n_disp     = DISP_BLANK;
                    end
                end else if (r_action == ACT_ABORT) begin
                    n_mode_reg = MODE_IDLE;
                    n_disp     = DISP_BLANK;
                end else begin
                    n_mode_reg = MODE_RUN;
                    n_disp     = DISP_BLANK;
                end
            end
            default: begin
                // stats: show the total once, leave on a second tick
                if (r_tick == TICK_NONE) begin
                    if (!r_total_shown) begin
                        n_disp        = DISP_TOTAL;
                        n_total_shown = 1'b1;
                    end
                end else if (sec) begin
                    n_mode_reg    = MODE_IDLE;
                    n_total_shown = 1'b0;
                    n_disp        = DISP_BLANK;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_reg    <= MODE_IDLE;
            r_remaining   <= '0;
            r_elapsed     <= '0;
            r_total       <= '0;
            r_buzz_cnt    <= '0;
            r_total_shown <= 1'b0;
        end else if (fire) begin
            r_mode_reg    <= n_mode_reg;
            r_remaining   <= n_remaining;
            r_elapsed     <= n_elapsed;
            r_total       <= n_total;
            r_buzz_cnt    <= n_buzz_cnt;
            r_total_shown <= n_total_shown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_mode  <= n_mode_reg;
            r_out_time  <= n_remaining;
            r_out_total <= n_total;
            r_out_disp  <= n_disp;
            r_out_beep  <= n_beep;
            r_out_rem   <= n_rem;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_mode             = r_out_mode;
    assign o_time_left        = r_out_time;
    assign o_productive_total = r_out_total;
    assign o_display_cmd      = r_out_disp;
    assign o_beep             = r_out_beep;
    assign o_reminder         = r_out_rem;

endmodule
